// ===== sv/sorted_set_intersection_assert.svh =====
// assertion macros used by the checker file
`ifndef SORTED_SET_INTERSECTION_ASSERT_SVH
`define SORTED_SET_INTERSECTION_ASSERT_SVH

// same-cycle implication
`define SSI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssi assertion failed");

// next-cycle implication
`define SSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssi assertion failed");

`endif

// ===== sv/ssi_pkg.sv =====
package ssi_pkg;

   localparam int SET_SIZE = 32;
   localparam int DATA_W   = 32;
   localparam int IDX_W    = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
   localparam int CNT_W    = $clog2(SET_SIZE + 1);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_A_RD,
      ST_B_SCAN,
      ST_SEL_START,
      ST_SEL_SCAN,
      ST_EMIT_START,
      ST_EMIT_RD,
      ST_EMIT_LOAD
   } ssi_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic clr_counts;
      logic i_clr;
      logic i_inc;
      logic j_clr;
      logic scan_step;
      logic flag_wr;
      logic sel_init;
      logic best_clr;
      logic sel_step;
      logic sel_commit;
      logic e_clr;
      logic out_load;
   } ssi_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic i_end;
      logic j_end;
      logic best_any;
      logic emit_last;
      logic out_free;
   } ssi_status_type;

endpackage

// ===== sv/ssi_if.sv =====
interface ssi_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [ssi_pkg::DATA_W-1:0]  value;
   logic                               to_set_b;
   logic                               final_item;

   modport source (output valid, output value, output to_set_b, output final_item,
                   input ready);
   modport sink   (input valid, input value, input to_set_b, input final_item,
                   output ready);
endinterface

interface ssi_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [ssi_pkg::DATA_W-1:0]  common_value;
   logic                               is_empty;
   logic                               last_of_run;

   modport source (output valid, output common_value, output is_empty,
                   output last_of_run, input ready);
   modport sink   (input valid, input common_value, input is_empty,
                   input last_of_run, output ready);
endinterface

// ===== sv/sorted_set_intersection.sv =====
// sorted set intersection
// req_chan: one word per value; to_set_b picks set b over set a, final_item
//   closes the load and starts the run. words beyond SET_SIZE in a set are dropped.
// rsp_chan: the distinct values present in both sets, ascending signed order,
//   last_of_run on the final word. an empty intersection gives a single word
//   with is_empty and last_of_run set and common_value zero.
// sequence: loading takes a word whenever req_valid is high. after the final
//   word the match pass compares one b entry per cycle against the held a
//   entry, then the sort pass runs one linear min-above-last scan of set a
//   per result plus a last scan that finds none, then each result word is
//   read out of the result memory and loaded into the output register. all
//   three stores are register arrays with one write and one registered read port.
// req ready is high only while loading; it rises again once the last result
//   word sits in the output register, so a new run can load while it waits.
// a stalled receiver holds the output word and pauses the emit sequence.
// reset (synchronous) clears the counts and returns to loading right away;
//   the stores need no clearing pass.
module sorted_set_intersection (
   input  logic      clock,
   input  logic      reset,
   ssi_req_if.sink   req_chan,
   ssi_rsp_if.source rsp_chan
);

   ssi_pkg::ssi_cmd_type    cmd;
   ssi_pkg::ssi_status_type status;
   logic                    req_ready;

   assign req_chan.ready = req_ready;

   // sequencer for load, match, sort and emit
   ssi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_final (req_chan.final_item),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // stores, counters, comparators and output register
   ssi_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_value        (req_chan.value),
      .req_to_set_b     (req_chan.to_set_b),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_common_value (rsp_chan.common_value),
      .rsp_is_empty     (rsp_chan.is_empty),
      .rsp_last_of_run  (rsp_chan.last_of_run)
   );

endmodule

// ===== sv/ssi_ctrl.sv =====
module ssi_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_final,
   output logic                    req_ready,
   input  ssi_pkg::ssi_status_type status,
   output ssi_pkg::ssi_cmd_type    cmd
);

   ssi_pkg::ssi_state_type state_ff, state_in;
   logic                   req_take;

   assign req_take = req_valid && (state_ff == ssi_pkg::ST_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssi_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssi_pkg::ST_LOAD: begin
            if (req_take && req_final) state_in = ssi_pkg::ST_A_RD;
         end
         ssi_pkg::ST_A_RD: begin
            state_in = status.i_end ? ssi_pkg::ST_SEL_START : ssi_pkg::ST_B_SCAN;
         end
         ssi_pkg::ST_B_SCAN: begin
            if (status.j_end) state_in = ssi_pkg::ST_A_RD;
         end
         ssi_pkg::ST_SEL_START: begin
            state_in = ssi_pkg::ST_SEL_SCAN;
         end
         ssi_pkg::ST_SEL_SCAN: begin
            if (status.i_end && !status.best_any) state_in = ssi_pkg::ST_EMIT_START;
         end
         ssi_pkg::ST_EMIT_START: begin
            state_in = ssi_pkg::ST_EMIT_RD;
         end
         ssi_pkg::ST_EMIT_RD: begin
            state_in = ssi_pkg::ST_EMIT_LOAD;
         end
         ssi_pkg::ST_EMIT_LOAD: begin
            if (status.out_free) begin
               state_in = status.emit_last ? ssi_pkg::ST_LOAD : ssi_pkg::ST_EMIT_RD;
            end
         end
         default: state_in = ssi_pkg::ST_LOAD;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ssi_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            cmd.load  = req_take;
            cmd.i_clr = req_take;
         end
         ssi_pkg::ST_A_RD: begin
            cmd.j_clr = 1'b1;
         end
         ssi_pkg::ST_B_SCAN: begin
            if (status.j_end) begin
               cmd.flag_wr = 1'b1;
               cmd.i_inc   = 1'b1;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ssi_pkg::ST_SEL_START: begin
            cmd.i_clr    = 1'b1;
            cmd.sel_init = 1'b1;
            cmd.best_clr = 1'b1;
         end
         ssi_pkg::ST_SEL_SCAN: begin
            if (status.i_end) begin
               cmd.sel_commit = status.best_any;
               cmd.best_clr   = 1'b1;
               cmd.i_clr      = 1'b1;
            end else begin
               cmd.sel_step = 1'b1;
               cmd.i_inc    = 1'b1;
            end
         end
         ssi_pkg::ST_EMIT_START: begin
            cmd.e_clr      = 1'b1;
            cmd.clr_counts = 1'b1;
         end
         ssi_pkg::ST_EMIT_RD: begin
         end
         ssi_pkg::ST_EMIT_LOAD: begin
            cmd.out_load = status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== sv/ssi_dpath.sv =====
module ssi_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  ssi_pkg::ssi_cmd_type              cmd,
   output ssi_pkg::ssi_status_type           status,
   input  logic signed [ssi_pkg::DATA_W-1:0] req_value,
   input  logic                              req_to_set_b,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [ssi_pkg::DATA_W-1:0] rsp_common_value,
   output logic                              rsp_is_empty,
   output logic                              rsp_last_of_run
);

   localparam int DW = ssi_pkg::DATA_W;
   localparam int IW = ssi_pkg::IDX_W;
   localparam int CW = ssi_pkg::CNT_W;
   localparam int SZ = ssi_pkg::SET_SIZE;

   // set and result stores
   logic [DW-1:0] a_mem [SZ];
   logic [DW-1:0] b_mem [SZ];
   logic [DW-1:0] c_mem [SZ];
   logic [DW-1:0] a_rd_ff, b_rd_ff, c_rd_ff;

   logic [CW-1:0] count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic [CW-1:0] k_ff, k_in, i_ff, i_in, j_ff, j_in, e_ff, e_in;
   logic          hit_ff, hit_in, have_last_ff, have_last_in;
   logic          best_valid_ff, best_valid_in, out_valid_ff, out_valid_in;
   logic [DW-1:0] best_ff, best_in, last_ff, best_next;
   logic [SZ-1:0] flag_ff;
   logic [DW-1:0] out_value_ff;
   logic          out_empty_ff, out_last_ff;

   logic          a_wr, b_wr, match, cand, best_next_valid;
   logic [CW-1:0] i_prev;

   assign a_wr = cmd.load && !req_to_set_b && (count_a_ff != CW'(SZ));
   assign b_wr = cmd.load &&  req_to_set_b && (count_b_ff != CW'(SZ));

   // j is one ahead of the registered b read
   assign match = (j_ff != '0) && (b_rd_ff == a_rd_ff);

   // next smallest flagged value above the last one taken
   assign i_prev = i_ff - CW'(1);
   assign cand   = (i_ff != '0) && flag_ff[i_prev[IW-1:0]]
                   && (!have_last_ff || ($signed(a_rd_ff) > $signed(last_ff)))
                   && (!best_valid_ff || ($signed(a_rd_ff) < $signed(best_ff)));
   assign best_next       = cand ? a_rd_ff : best_ff;
   assign best_next_valid = best_valid_ff || cand;

   assign status.i_end     = (i_ff == count_a_ff);
   assign status.j_end     = (j_ff == count_b_ff);
   assign status.best_any  = best_next_valid;
   assign status.emit_last = (k_ff == '0) || ((e_ff + CW'(1)) == k_ff);
   assign status.out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      count_a_in    = count_a_ff;
      count_b_in    = count_b_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      e_in          = e_ff;
      hit_in        = hit_ff;
      have_last_in  = have_last_ff;
      best_valid_in = best_valid_ff;
      best_in       = best_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;

      if (cmd.clr_counts) begin
         count_a_in = '0;
         count_b_in = '0;
      end
      if (a_wr) count_a_in = count_a_ff + CW'(1);
      if (b_wr) count_b_in = count_b_ff + CW'(1);

      if (cmd.i_clr) i_in = '0;
      if (cmd.i_inc) i_in = i_ff + CW'(1);

      if (cmd.j_clr) begin
         j_in   = '0;
         hit_in = 1'b0;
      end
      if (cmd.scan_step) begin
         j_in   = j_ff + CW'(1);
         hit_in = hit_ff || match;
      end

      if (cmd.sel_init) begin
         k_in         = '0;
         have_last_in = 1'b0;
      end
      if (cmd.sel_step) begin
         best_in       = best_next;
         best_valid_in = best_next_valid;
      end
      if (cmd.best_clr) best_valid_in = 1'b0;
      if (cmd.sel_commit) begin
         k_in         = k_ff + CW'(1);
         have_last_in = 1'b1;
      end

      if (cmd.e_clr) e_in = '0;
      if (cmd.out_load) begin
         e_in         = e_ff + CW'(1);
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff    <= '0;
         count_b_ff    <= '0;
         k_ff          <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         e_ff          <= '0;
         hit_ff        <= 1'b0;
         have_last_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_a_ff    <= count_a_in;
         count_b_ff    <= count_b_in;
         k_ff          <= k_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         e_ff          <= e_in;
         hit_ff        <= hit_in;
         have_last_ff  <= have_last_in;
         best_valid_ff <= best_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers and memories
   always_ff @(posedge clock) begin
      if (a_wr) a_mem[count_a_ff[IW-1:0]] <= req_value;
      if (b_wr) b_mem[count_b_ff[IW-1:0]] <= req_value;
      if (cmd.sel_commit) c_mem[k_ff[IW-1:0]] <= best_next;
      a_rd_ff <= a_mem[i_ff[IW-1:0]];
      b_rd_ff <= b_mem[j_ff[IW-1:0]];
      c_rd_ff <= c_mem[e_ff[IW-1:0]];
      best_ff <= best_in;
      if (cmd.sel_commit) last_ff <= best_next;
      if (cmd.flag_wr) flag_ff[i_ff[IW-1:0]] <= hit_ff || match;
      if (cmd.out_load) begin
         out_value_ff <= (k_ff == '0) ? '0 : c_rd_ff;
         out_empty_ff <= (k_ff == '0);
         out_last_ff  <= status.emit_last;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_common_value = out_value_ff;
   assign rsp_is_empty     = out_empty_ff;
   assign rsp_last_of_run  = out_last_ff;

endmodule

// ===== sv/sorted_set_intersection_chk.sv =====
`include "sorted_set_intersection_assert.svh"

module sorted_set_intersection_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [ssi_pkg::DATA_W-1:0] rsp_common_value,
   input logic                              rsp_is_empty,
   input logic                              rsp_last_of_run
);

   logic                              rsp_take;
   logic                              prev_valid_ff, prev_valid_in;
   logic signed [ssi_pkg::DATA_W-1:0] prev_ff;

   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      prev_valid_in = prev_valid_ff;
      if (rsp_take) prev_valid_in = !rsp_last_of_run;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_valid_ff <= 1'b0;
      end else begin
         prev_valid_ff <= prev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_take) prev_ff <= rsp_common_value;
   end

   `SSI_ASSERT_NEXT(rsp_idle_after_reset, clock, 1'b0, reset, !rsp_valid)
   `SSI_ASSERT_NEXT(rsp_holds_when_stalled, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_common_value))
   `SSI_ASSERT_SAME(empty_is_lone_zero, clock, reset, rsp_valid && rsp_is_empty, rsp_last_of_run && (rsp_common_value == '0) && !prev_valid_ff)
   `SSI_ASSERT_SAME(run_strictly_ascends, clock, reset, rsp_valid && prev_valid_ff, !rsp_is_empty && (rsp_common_value > prev_ff))

endmodule

bind sorted_set_intersection sorted_set_intersection_chk u_chk (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_common_value (rsp_chan.common_value),
   .rsp_is_empty     (rsp_chan.is_empty),
   .rsp_last_of_run  (rsp_chan.last_of_run)
);

// ===== tb/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS  = 420;  // random request words to send
   localparam int CALM_FROM     = 360;  // no idling once this many random words went out
   localparam int LONG_HOLD     = 3000; // cycles of the long receiver stall, beyond a worst run
   localparam int DRAIN_CYCLES  = 2500; // idle wait after the drain, longer than a worst run after the final word
   localparam int DIRECTED_ROWS = 25;
   localparam int SHOW_LIMIT    = 10;

   localparam logic signed [ssi_pkg::DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
   localparam logic signed [ssi_pkg::DATA_W-1:0] MOST_POS = 32'sh7fff_ffff;

   // one response word
   typedef struct packed {
      logic signed [ssi_pkg::DATA_W-1:0] common_value;
      logic                              is_empty;
      logic                              last_of_run;
   } common_word_type;

   // one row of the directed table; known_result marks a final word whose
   // single response word is written out in the row itself
   typedef struct packed {
      logic signed [ssi_pkg::DATA_W-1:0] value;
      logic                              to_b;
      logic                              fin;
      logic                              known_result;
      logic signed [ssi_pkg::DATA_W-1:0] known_value;
      logic                              known_empty;
   } load_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ssi_req_if req_chan ();
   ssi_rsp_if rsp_chan ();

   sorted_set_intersection i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #4ns clock = ~clock;

   // ------------------------------------------------------------------
   // directed table
   // ------------------------------------------------------------------
   load_row_type directed_rows [DIRECTED_ROWS] = '{
      // both sets hold only the most negative value
      '{MOST_NEG, 1'b0, 1'b0, 1'b0, 0, 1'b0},
      '{MOST_NEG, 1'b1, 1'b1, 1'b1, MOST_NEG, 1'b0},
      // both sets hold only the most positive value, b loaded first
      '{MOST_POS, 1'b1, 1'b0, 1'b0, 0, 1'b0},
      '{MOST_POS, 1'b0, 1'b1, 1'b1, MOST_POS, 1'b0},
      // set b empty
      '{0,        1'b0, 1'b1, 1'b1, 0, 1'b1},
      // set a empty
      '{5,        1'b1, 1'b1, 1'b1, 0, 1'b1},
      // disjoint sets
      '{1,        1'b0, 1'b0, 1'b0, 0, 1'b0},
      '{2,        1'b1, 1'b1, 1'b1, 0, 1'b1},
      // duplicates in both sets, result needs dedup and sort
      '{7,        1'b0, 1'b0, 1'b0, 0, 1'b0},
      '{7,        1'b0, 1'b0, 1'b0, 0, 1'b0},
      '{3,        1'b0, 1'b0, 1'b0, 0, 1'b0},
      '{7,        1'b1, 1'b0, 1'b0, 0, 1'b0},
      '{3,        1'b1, 1'b0, 1'b0, 0, 1'b0},
      '{3,        1'b1, 1'b0, 1'b0, 0, 1'b0},
      '{9,        1'b1, 1'b1, 1'b0, 0, 1'b0},
      // signed ordering around zero
      '{-1,       1'b0, 1'b0, 1'b0, 0, 1'b0},
      '{1,        1'b0, 1'b0, 1'b0, 0, 1'b0},
      '{0,        1'b0, 1'b0, 1'b0, 0, 1'b0},
      '{1,        1'b1, 1'b0, 1'b0, 0, 1'b0},
      '{-1,       1'b1, 1'b0, 1'b0, 0, 1'b0},
      '{0,        1'b1, 1'b1, 1'b0, 0, 1'b0},
      // both extremes common, most negative must come out first
      '{MOST_POS, 1'b0, 1'b0, 1'b0, 0, 1'b0},
      '{MOST_NEG, 1'b0, 1'b0, 1'b0, 0, 1'b0},
      '{MOST_POS, 1'b1, 1'b0, 1'b0, 0, 1'b0},
      '{MOST_NEG, 1'b1, 1'b1, 1'b0, 0, 1'b0}
   };

   // ------------------------------------------------------------------
   // shadow of the block: the two sets and their fill counts
   // ------------------------------------------------------------------
   logic signed [ssi_pkg::DATA_W-1:0] shadow_a [ssi_pkg::SET_SIZE];
   logic signed [ssi_pkg::DATA_W-1:0] shadow_b [ssi_pkg::SET_SIZE];
   int                                shadow_count_a = 0;
   int                                shadow_count_b = 0;

   common_word_type expected_words [$];  // response words still owed by the block

   int  mismatches   = 0;
   int  random_words = 0;
   bit  calm         = 1'b0;  // set near the end: both sides stop idling
   bit  long_hold_req = 1'b0; // asks the receiver for one long stall

   // intersect the shadow sets, dedup, sort ascending (signed), queue the words
   function automatic void queue_intersection();
      logic signed [ssi_pkg::DATA_W-1:0] common [ssi_pkg::SET_SIZE];
      common_word_type                   word;
      int                                n;
      int                                pos;
      int                                i;
      int                                j;
      bit                                hit;
      n = 0;
      for (i = 0; i < shadow_count_a; i++) begin
         hit = 1'b0;
         for (j = 0; j < shadow_count_b; j++) begin
            if (shadow_b[j] == shadow_a[i]) hit = 1'b1;
         end
         if (hit) begin
            pos = 0;
            while (pos < n && common[pos] < shadow_a[i]) pos++;
            // insert unless already present
            if (!(pos < n && common[pos] == shadow_a[i])) begin
               for (j = n; j > pos; j--) common[j] = common[j-1];
               common[pos] = shadow_a[i];
               n++;
            end
         end
      end
      if (n == 0) begin
         word = '{0, 1'b1, 1'b1};
         expected_words.push_back(word);
      end
      for (i = 0; i < n; i++) begin
         word = '{common[i], 1'b0, (i == n - 1)};
         expected_words.push_back(word);
      end
   endfunction

   // track one accepted request word; a final word ends the run
   function automatic void shadow_load(logic signed [ssi_pkg::DATA_W-1:0] value,
                                       logic to_b, logic fin, logic known_result,
                                       logic signed [ssi_pkg::DATA_W-1:0] known_value,
                                       logic known_empty);
      common_word_type word;
      // words past SET_SIZE in a set are dropped
      if (to_b) begin
         if (shadow_count_b < ssi_pkg::SET_SIZE) begin
            shadow_b[shadow_count_b] = value;
            shadow_count_b++;
         end
      end else begin
         if (shadow_count_a < ssi_pkg::SET_SIZE) begin
            shadow_a[shadow_count_a] = value;
            shadow_count_a++;
         end
      end
      if (fin) begin
         if (known_result) begin
            word = '{known_value, known_empty, 1'b1};
            expected_words.push_back(word);
         end else begin
            queue_intersection();
         end
         shadow_count_a = 0;
         shadow_count_b = 0;
      end
   endfunction

   // ------------------------------------------------------------------
   // request side: drive at falling edge, accept at rising edge
   // ------------------------------------------------------------------
   task automatic send_word(logic signed [ssi_pkg::DATA_W-1:0] value, logic to_b, logic fin,
                            logic known_result,
                            logic signed [ssi_pkg::DATA_W-1:0] known_value,
                            logic known_empty);
      int gap;
      // idle burst before this word
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 10);
         repeat (gap) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.value      <= value;
      req_chan.to_set_b   <= to_b;
      req_chan.final_item <= fin;
      do @(posedge clock); while (!(req_chan.valid === 1'b1 && req_chan.ready === 1'b1));
      shadow_load(value, to_b, fin, known_result, known_value, known_empty);
   endtask

   // a pool entry: extreme, small or random; runs draw mostly from the pool so the sets overlap
   function automatic logic signed [ssi_pkg::DATA_W-1:0] pool_value(int pick);
      logic signed [ssi_pkg::DATA_W-1:0] v;
      case (pick)
         0:       v = MOST_NEG;
         1:       v = MOST_POS;
         2:       v = $signed($urandom_range(0, 8)) - 4;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // one random run: a shuffled mix of a and b words ending in the final word
   task automatic random_run();
      logic signed [ssi_pkg::DATA_W-1:0] pool [8];
      logic signed [ssi_pkg::DATA_W-1:0] v;
      int                                left_a;
      int                                left_b;
      int                                k;
      bit                                noisy;
      bit                                b;
      bit                                fin;
      for (k = 0; k < 8; k++) pool[k] = pool_value($urandom_range(0, 5));
      noisy = ($urandom_range(0, 9) == 0);
      // mostly small sets, now and then sizes that reach or pass SET_SIZE
      if ($urandom_range(0, 7) == 0) begin
         left_a = $urandom_range(ssi_pkg::SET_SIZE - 12, ssi_pkg::SET_SIZE + 8);
         left_b = $urandom_range(ssi_pkg::SET_SIZE - 12, ssi_pkg::SET_SIZE + 8);
      end else begin
         left_a = $urandom_range(0, 10);
         left_b = $urandom_range(0, 10);
      end
      if (left_a + left_b == 0) begin
         if ($urandom_range(0, 1) == 1) left_a = 1;
         else left_b = 1;
      end
      while (left_a + left_b > 0) begin
         if (left_a == 0) b = 1'b1;
         else if (left_b == 0) b = 1'b0;
         else b = ($urandom_range(1, left_a + left_b) > left_a);
         fin = (left_a + left_b == 1);
         if (b) left_b--;
         else left_a--;
         v = (noisy || $urandom_range(0, 9) == 0) ? $signed($urandom)
                                                  : pool[$urandom_range(0, 7)];
         send_word(v, b, fin, 1'b0, 0, 1'b0);
         random_words++;
         calm = (random_words >= CALM_FROM);
      end
   endtask

   // ------------------------------------------------------------------
   // response side: ready with random stall bursts, one long stall on request
   // ------------------------------------------------------------------
   initial begin : rsp_ready_drive
      int hold;
      hold = 0;
      rsp_chan.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold = LONG_HOLD;
         end
         if (hold > 0) begin
            hold--;
            rsp_chan.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 10) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // compare every accepted response word with the oldest expectation
   always @(posedge clock) begin : rsp_compare
      common_word_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
               $display("%0t unexpected word: value %0d empty %b last %b", $realtime,
                        rsp_chan.common_value, rsp_chan.is_empty, rsp_chan.last_of_run);
         end else begin
            want = expected_words.pop_front();
            if (rsp_chan.common_value !== want.common_value ||
                rsp_chan.is_empty     !== want.is_empty ||
                rsp_chan.last_of_run  !== want.last_of_run) begin
               mismatches++;
               if (mismatches <= SHOW_LIMIT)
                  $display({"%0t word mismatch: expected value %0d empty %b last %b,",
                            " got value %0d empty %b last %b"},
                           $realtime, want.common_value, want.is_empty, want.last_of_run,
                           rsp_chan.common_value, rsp_chan.is_empty, rsp_chan.last_of_run);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      int row;
      int run;
      req_chan.valid      = 1'b0;
      req_chan.value      = '0;
      req_chan.to_set_b   = 1'b0;
      req_chan.final_item = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows first
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         send_word(directed_rows[row].value, directed_rows[row].to_b, directed_rows[row].fin,
                   directed_rows[row].known_result, directed_rows[row].known_value,
                   directed_rows[row].known_empty);
      end

      // random runs
      run = 0;
      while (random_words < RANDOM_WORDS) begin
         // receiver stalls long while the sender keeps offering, so the
         // block backs up and drops req ready
         if (run == 3) long_hold_req = 1'b1;
         // sender goes quiet until the block has delivered everything
         if (run == 8) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
            while (expected_words.size() != 0) @(posedge clock);
         end
         random_run();
         run++;
      end
      @(negedge clock);
      req_chan.valid <= 1'b0;

      // drain, then give the block time to show any stray word
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin : run_limit
      #8ms;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/ssi_pkg.sv
sv/ssi_if.sv
sv/ssi_ctrl.sv
sv/ssi_dpath.sv
sv/sorted_set_intersection.sv
sv/sorted_set_intersection_chk.sv
tb/tb_top.sv
